>>> rtl/tcpi_pkg.sv
// Shared types and constants for the text cell palette indexer.
`timescale 1ns / 1ps
`default_nettype none

package tcpi_pkg;

  // Field widths
  localparam int CHAR_W      = 8;
  localparam int COLOR_W     = 24;
  localparam int ADDR_W      = 16;
  localparam int ATTR_W      = 8;
  localparam int IDX_FIELD_W = 4;
  localparam int DIM_W       = 9;
  localparam int CNT8_W      = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;

  localparam logic [DIM_W-1:0] COLUMNS_RST = 9'd80;
  localparam logic [DIM_W-1:0] ROWS_RST    = 9'd25;
  localparam logic [DIM_W-1:0] DIM_MAX     = 9'd256;

  // Palette and queue sizing
  localparam int PALETTE_SIZE_DEF = 16;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  // One cell between the address front end and the palette back end
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
    logic               last;
  } q_entry_t;

endpackage

`default_nettype wire

>>> rtl/tcpi_front.sv
// Front end: takes cells, holds geometry registers, computes address and last flag.
`timescale 1ns / 1ps
`default_nettype none

module tcpi_front (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [tcpi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [tcpi_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [tcpi_pkg::CHAR_W-1:0]         in_char_code,
  input  wire  [tcpi_pkg::COLOR_W-1:0]        in_fore_color,
  input  wire  [tcpi_pkg::COLOR_W-1:0]        in_back_color,
  input  wire                                 q_ready,
  output logic                                q_push,
  output tcpi_pkg::q_entry_t                  q_entry
);
  import tcpi_pkg::*;

  logic [DIM_W-1:0]  columns_r, rows_r;
  logic [CNT8_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [DIM_W-1:0]  ncols, nrows;
  logic [DIM_W+CNT8_W-1:0] addr_full;
  logic              row_wrap, col_wrap;

  // Clamp a dimension register to 1..256
  function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    begin
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_MAX) r = DIM_MAX;
      else r = v;
      return r;
    end
  endfunction

  assign ncols = dim_eff(columns_r);
  assign nrows = dim_eff(rows_r);

  // Hold geometry registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RST;
      rows_r    <= ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: columns_r <= cfg_wdata;
        REG_ROWS:    rows_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Build the queue entry from the current position
  assign addr_full = (DIM_W+CNT8_W)'(col_r) + (DIM_W+CNT8_W)'(row_r) * (DIM_W+CNT8_W)'(ncols);

  always_comb begin
    q_entry.addr      = addr_full[ADDR_W-1:0];
    q_entry.char_code = in_char_code;
    q_entry.fore      = in_fore_color;
    q_entry.back      = in_back_color;
    q_entry.last      = ({1'b0, row_r} == nrows - DIM_W'(1)) &&
                        ({1'b0, col_r} == ncols - DIM_W'(1));
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  // Advance down the column, then to the next column
  assign row_wrap = ({1'b0, row_r} + DIM_W'(1)) >= nrows;
  assign col_wrap = ({1'b0, col_r} + DIM_W'(1)) >= ncols;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (q_push) begin
      if (row_wrap) begin
        row_nxt = '0;
        col_nxt = col_wrap ? '0 : col_r + CNT8_W'(1);
      end else begin
        row_nxt = row_r + CNT8_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcpi_fifo.sv
// Short queue between front end and palette back end.
`timescale 1ns / 1ps
`default_nettype none

module tcpi_fifo (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  tcpi_pkg::q_entry_t  wr_data,
  output logic                not_full,
  output logic                not_empty,
  input  wire                 pop,
  output tcpi_pkg::q_entry_t  rd_data
);
  import tcpi_pkg::*;

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign not_full  = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

  property p_no_overrun;
    @(posedge clk) disable iff (!rst_n) push |-> (cnt_r < QCNT_W'(QUEUE_DEPTH));
  endproperty
  a_no_overrun: assert property (p_no_overrun) else $error("queue written while full");

  property p_no_underrun;
    @(posedge clk) disable iff (!rst_n) pop |-> (cnt_r != '0);
  endproperty
  a_no_underrun: assert property (p_no_underrun) else $error("queue read while empty");

endmodule

`default_nettype wire

>>> rtl/tcpi_back.sv
// Back end: palette match and append, attribute packing, output register.
`timescale 1ns / 1ps
`default_nettype none

module tcpi_back #(
  parameter int PALETTE_SIZE = tcpi_pkg::PALETTE_SIZE_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             q_valid,
  output logic                            q_pop,
  input  tcpi_pkg::q_entry_t              q_entry,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [tcpi_pkg::ADDR_W-1:0]     out_cell_address,
  output logic [tcpi_pkg::CHAR_W-1:0]     out_char_out,
  output logic [tcpi_pkg::ATTR_W-1:0]     out_attribute,
  output logic                            out_fore_new,
  output logic                            out_back_new,
  output logic                            out_palette_overflow,
  output logic                            out_last_cell
);
  import tcpi_pkg::*;

  localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
  localparam logic [IDX_W-1:0] OVF_IDX = IDX_W'(PALETTE_SIZE - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(PALETTE_SIZE);

  logic [COLOR_W-1:0]  pal_r [PALETTE_SIZE];
  logic [CNT_W-1:0]    count_r, count_mid, count_nxt;
  logic [PALETTE_SIZE-1:0] fg_vec, bg_vec;
  logic [IDX_W-1:0]    fg_enc, bg_enc, fg_sel, bg_sel;
  logic                fg_hit, bg_hit, full0, full1;
  logic                fnew, bnew, ovf;
  logic                out_valid_r;

  // Compare against every written entry
  always_comb begin
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      fg_vec[i] = (CNT_W'(i) < count_r) && (pal_r[i] == q_entry.fore);
      bg_vec[i] = (CNT_W'(i) < count_r) && (pal_r[i] == q_entry.back);
    end
  end

  // Pick the lowest matching index
  always_comb begin
    fg_enc = '0;
    bg_enc = '0;
    for (int i = PALETTE_SIZE - 1; i >= 0; i--) begin
      if (fg_vec[i]) fg_enc = IDX_W'(i);
      if (bg_vec[i]) bg_enc = IDX_W'(i);
    end
  end

  // Foreground first, then background sees the foreground append
  always_comb begin
    fg_hit    = |fg_vec;
    full0     = (count_r == FULL_CNT);
    fnew      = !fg_hit && !full0;
    fg_sel    = fg_hit ? fg_enc : (full0 ? OVF_IDX : count_r[IDX_W-1:0]);
    count_mid = count_r + CNT_W'(fnew);
    full1     = (count_mid == FULL_CNT);
    if (|bg_vec) begin
      bg_hit = 1'b1;
      bg_sel = bg_enc;
    end else if (fnew && (q_entry.back == q_entry.fore)) begin
      bg_hit = 1'b1;
      bg_sel = count_r[IDX_W-1:0];
    end else begin
      bg_hit = 1'b0;
      bg_sel = full1 ? OVF_IDX : count_mid[IDX_W-1:0];
    end
    bnew      = !bg_hit && !full1;
    ovf       = (!fg_hit && full0) || (!bg_hit && full1);
    count_nxt = count_mid + CNT_W'(bnew);
  end

  // Take an entry when the output register is free or being drained
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // Append new colors
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (fnew) pal_r[count_r[IDX_W-1:0]]   <= q_entry.fore;
      if (bnew) pal_r[count_mid[IDX_W-1:0]] <= q_entry.back;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (q_pop) begin
      count_r <= count_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_cell_address     <= q_entry.addr;
      out_char_out         <= q_entry.char_code;
      out_attribute        <= {IDX_FIELD_W'(bg_sel), IDX_FIELD_W'(fg_sel)};
      out_fore_new         <= fnew;
      out_back_new         <= bnew;
      out_palette_overflow <= ovf;
      out_last_cell        <= q_entry.last;
    end
  end

  assign out_valid = out_valid_r;

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= FULL_CNT;
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("palette count too large");

  property p_count_hold;
    @(posedge clk) disable iff (!rst_n) !q_pop |=> $stable(count_r);
  endproperty
  a_count_hold: assert property (p_count_hold) else $error("palette count moved without transfer");

  property p_ovf_full;
    @(posedge clk) disable iff (!rst_n) (q_pop && ovf) |=> (count_r == FULL_CNT);
  endproperty
  a_ovf_full: assert property (p_ovf_full) else $error("overflow flagged with room left");

  property p_new_grows;
    @(posedge clk) disable iff (!rst_n)
      q_pop |=> (count_r == $past(count_r) + CNT_W'($past(fnew)) + CNT_W'($past(bnew)));
  endproperty
  a_new_grows: assert property (p_new_grows) else $error("palette count out of step with flags");

endmodule

`default_nettype wire

>>> rtl/text_cell_palette_indexer_top.sv
// Top level of the text cell palette indexer.
//
//  Channel  Handshake            Payload
//  in       in_valid/in_ready    in_char_code, in_fore_color, in_back_color
//  out      out_valid/out_ready  out_cell_address, out_char_out, out_attribute,
//                                out_fore_new, out_back_new, out_palette_overflow,
//                                out_last_cell
//  cfg      cfg_we               cfg_index, cfg_wdata (0 columns, 1 rows)
//
// One cell per cycle sustained while the output is not stalled; a cell passes through a
// queue slot and then through the palette compare into the output register. The path
// that sets the cycle is the 16-way color compare with the chained foreground/background
// append.
// Reset (synchronous, rst_n low) clears counters, queue, palette count and
// output valid; geometry returns to 80 x 25.
// A stalled output fills a four-entry queue before in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module text_cell_palette_indexer_top #(
  parameter int PALETTE_SIZE = tcpi_pkg::PALETTE_SIZE_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [tcpi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [tcpi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [tcpi_pkg::CHAR_W-1:0]      in_char_code,
  input  wire  [tcpi_pkg::COLOR_W-1:0]     in_fore_color,
  input  wire  [tcpi_pkg::COLOR_W-1:0]     in_back_color,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [tcpi_pkg::ADDR_W-1:0]      out_cell_address,
  output logic [tcpi_pkg::CHAR_W-1:0]      out_char_out,
  output logic [tcpi_pkg::ATTR_W-1:0]      out_attribute,
  output logic                             out_fore_new,
  output logic                             out_back_new,
  output logic                             out_palette_overflow,
  output logic                             out_last_cell
);
  import tcpi_pkg::*;

  q_entry_t wr_entry, rd_entry;
  logic     push, pop, not_full, not_empty;

  tcpi_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_code  (in_char_code),
    .in_fore_color (in_fore_color),
    .in_back_color (in_back_color),
    .q_ready       (not_full),
    .q_push        (push),
    .q_entry       (wr_entry)
  );

  tcpi_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (wr_entry),
    .not_full  (not_full),
    .not_empty (not_empty),
    .pop       (pop),
    .rd_data   (rd_entry)
  );

  tcpi_back #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (not_empty),
    .q_pop                (pop),
    .q_entry              (rd_entry),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_cell_address     (out_cell_address),
    .out_char_out         (out_char_out),
    .out_attribute        (out_attribute),
    .out_fore_new         (out_fore_new),
    .out_back_new         (out_back_new),
    .out_palette_overflow (out_palette_overflow),
    .out_last_cell        (out_last_cell)
  );

endmodule

`default_nettype wire

>>> tb/sv/text_cell_palette_indexer_top_tb.sv
// Self-checking testbench for the text cell palette indexer top level.
`timescale 1ns / 1ps

module text_cell_palette_indexer_top_tb;
  import tcpi_pkg::*;

  localparam int PAL_SIZE        = PALETTE_SIZE_DEF;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int RX_HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CHUNK_CELLS     = 100;

  typedef struct packed {
    logic [ADDR_W-1:0] cell_address;
    logic [CHAR_W-1:0] char_out;
    logic [ATTR_W-1:0] attribute;
    logic              fore_new;
    logic              back_new;
    logic              palette_overflow;
    logic              last_cell;
  } cell_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_COLUMNS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_char_code = '0;
  logic [COLOR_W-1:0]    in_fore_color = '0;
  logic [COLOR_W-1:0]    in_back_color = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ADDR_W-1:0]     out_cell_address;
  logic [CHAR_W-1:0]     out_char_out;
  logic [ATTR_W-1:0]     out_attribute;
  logic                  out_fore_new;
  logic                  out_back_new;
  logic                  out_palette_overflow;
  logic                  out_last_cell;

  text_cell_palette_indexer_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_char_code        (in_char_code),
    .in_fore_color       (in_fore_color),
    .in_back_color       (in_back_color),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cell_address    (out_cell_address),
    .out_char_out        (out_char_out),
    .out_attribute       (out_attribute),
    .out_fore_new        (out_fore_new),
    .out_back_new        (out_back_new),
    .out_palette_overflow(out_palette_overflow),
    .out_last_cell       (out_last_cell)
  );

  always #1 clk = ~clk;

  // Predictor state: palette, scan position and geometry
  logic [COLOR_W-1:0] pal_colors [PAL_SIZE];
  int                 pal_count = 0;
  int                 row_pos = 0;
  int                 col_pos = 0;
  logic [DIM_W-1:0]   geom_cols = COLUMNS_RST;
  logic [DIM_W-1:0]   geom_rows = ROWS_RST;

  cell_result_t expected_cells [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic rx_hold = 1'b0;
  event hold_trigger;

  int errors = 0;
  int cells_sent = 0;
  int results_checked = 0;
  int image_ends = 0;
  int overflows = 0;
  int geometries = 0;
  int quiet_cycles = 0;
  int in_stall_cycles = 0;

  function automatic int eff_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return int'(DIM_MAX);
    return int'(v);
  endfunction

  // Look a color up; append it while there is room, else flag overflow
  function automatic logic [IDX_FIELD_W-1:0] palette_index(input logic [COLOR_W-1:0] color,
                                                           output logic added,
                                                           inout logic full_hit);
    added = 1'b0;
    for (int i = 0; i < pal_count; i++)
      if (pal_colors[i] == color) return IDX_FIELD_W'(i);
    if (pal_count < PAL_SIZE) begin
      pal_colors[pal_count] = color;
      added = 1'b1;
      pal_count++;
      return IDX_FIELD_W'(pal_count - 1);
    end
    full_hit = 1'b1;
    return IDX_FIELD_W'(PAL_SIZE - 1);
  endfunction

  function automatic cell_result_t predict_cell(input logic [CHAR_W-1:0] ch,
                                                input logic [COLOR_W-1:0] fg,
                                                input logic [COLOR_W-1:0] bg);
    cell_result_t r;
    int ncols;
    int nrows;
    logic fnew;
    logic bnew;
    logic ovf;
    logic [IDX_FIELD_W-1:0] fi;
    logic [IDX_FIELD_W-1:0] bi;
    ncols = eff_dim(geom_cols);
    nrows = eff_dim(geom_rows);
    ovf = 1'b0;
    // foreground first, so an equal background finds it
    fi = palette_index(fg, fnew, ovf);
    bi = palette_index(bg, bnew, ovf);
    r.cell_address     = ADDR_W'(col_pos + row_pos * ncols);
    r.char_out         = ch;
    r.attribute        = {bi, fi};
    r.fore_new         = fnew;
    r.back_new         = bnew;
    r.palette_overflow = ovf;
    r.last_cell        = (row_pos == nrows - 1) && (col_pos == ncols - 1);
    // advance down the column, then to the next column
    if (row_pos + 1 >= nrows) begin
      row_pos = 0;
      col_pos = (col_pos + 1 >= ncols) ? 0 : col_pos + 1;
    end else begin
      row_pos++;
    end
    return r;
  endfunction

  function automatic logic [COLOR_W-1:0] unseen_color();
    logic [COLOR_W-1:0] c;
    logic hit;
    do begin
      c = COLOR_W'($urandom);
      hit = 1'b0;
      for (int i = 0; i < pal_count; i++)
        if (pal_colors[i] == c) hit = 1'b1;
    end while (hit);
    return c;
  endfunction

  function automatic logic [COLOR_W-1:0] known_color();
    if (pal_count == 0) return unseen_color();
    return pal_colors[$urandom_range(pal_count - 1)];
  endfunction

  // Offer one cell and hold it until the transfer; valid stays high afterwards
  task automatic send_cell(input logic [CHAR_W-1:0] ch,
                           input logic [COLOR_W-1:0] fg,
                           input logic [COLOR_W-1:0] bg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_code  <= ch;
    in_fore_color <= fg;
    in_back_color <= bg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_cells.push_back(predict_cell(ch, fg, bg));
    cells_sent++;
  endtask

  // Mostly palette hits, with new colors and equal fore/back mixed in
  task automatic send_random_cell();
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    int pick;
    pick = $urandom_range(99);
    fg = known_color();
    bg = known_color();
    if (pick < 10) begin
      fg = unseen_color();
    end else if (pick < 20) begin
      bg = unseen_color();
    end else if (pick < 25) begin
      fg = unseen_color();
      bg = unseen_color();
    end else if (pick < 32) begin
      bg = fg;
    end
    send_cell(CHAR_W'($urandom), fg, bg);
  endtask

  // Drop valid and wait for every pending result
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write both geometry registers; only called while idle
  task automatic set_geometry(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_wdata <= cols;
    @(posedge clk);
    geom_cols = cols;
    cfg_index <= REG_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    geom_rows = rows;
    cfg_we <= 1'b0;
    geometries++;
  endtask

  task automatic test_palette_fill();
    logic [COLOR_W-1:0] c;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_cell(8'h00, 24'h000000, 24'hFFFFFF);
    // background equal to a foreground that is new on this cell
    send_cell(8'hFF, 24'h0000FF, 24'h0000FF);
    send_cell(8'h41, 24'hFFFFFF, 24'h000000);
    send_cell(8'h80, 24'h00FF00, 24'hFF0000);
    send_cell(8'h7F, 24'hA5A5A5, 24'h5A5A5A);
    // fill up; the last background lands on a full palette
    while (pal_count < PAL_SIZE)
      send_cell(CHAR_W'($urandom), unseen_color(), unseen_color());
    // full palette: unseen foreground, unseen background, both, and equal
    send_cell(8'h01, unseen_color(), pal_colors[3]);
    send_cell(8'hFE, pal_colors[0], unseen_color());
    send_cell(8'h55, unseen_color(), unseen_color());
    c = unseen_color();
    send_cell(8'hAA, c, c);
    send_cell(8'h20, pal_colors[PAL_SIZE - 1], pal_colors[PAL_SIZE - 1]);
    finish_phase();
  endtask

  task automatic run_geometry(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows,
                              input int n);
    set_geometry(cols, rows);
    repeat (n) send_random_cell();
    finish_phase();
  endtask

  // Extremes and out-of-range values; counters left beyond the new limits
  task automatic test_geometry_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_geometry(9'd256, 9'd256, 4);
    run_geometry(9'd511, 9'd300, 2);
    run_geometry(9'd3,   9'd2,   7);
    run_geometry(9'd300, 9'd0,   3);
    run_geometry(9'd1,   9'd1,   3);
    run_geometry(9'd0,   9'd0,   2);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 4; k++) begin
      // mostly small images so the end of image comes often
      if ($urandom_range(7) == 0) begin
        cols = DIM_W'($urandom_range(511));
        rows = DIM_W'($urandom_range(511));
      end else begin
        cols = DIM_W'($urandom_range(10, 1));
        rows = DIM_W'($urandom_range(10, 1));
      end
      run_geometry(cols, rows, CHUNK_CELLS);
    end
  endtask

  // Hold the output off while cells keep coming, so the input stalls
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_geometry(9'd4, 9'd3);
    -> hold_trigger;
    repeat (24) send_random_cell();
    finish_phase();
  endtask

  always begin
    @(hold_trigger);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Check each output transfer against the oldest pending cell
  always @(posedge clk) begin : result_check
    cell_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        $error("result with no cell pending: cell_address %0h", out_cell_address);
        errors++;
      end else begin
        e = expected_cells.pop_front();
        report_field("cell_address", e.cell_address, out_cell_address);
        report_field("char_out", e.char_out, out_char_out);
        report_field("attribute", e.attribute, out_attribute);
        report_field("fore_new", e.fore_new, out_fore_new);
        report_field("back_new", e.back_new, out_back_new);
        report_field("palette_overflow", e.palette_overflow, out_palette_overflow);
        report_field("last_cell", e.last_cell, out_last_cell);
        results_checked++;
        if (e.last_cell) image_ends++;
        if (e.palette_overflow) overflows++;
      end
    end
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Count cycles without any transfer, and cycles with the input stalled
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && in_valid && !in_ready) in_stall_cycles <= in_stall_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_palette_fill();
    test_geometry_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(78, 0);
    test_random_traffic(0, 78);
    test_random_traffic(38, 38);
    test_output_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_cells.size() != 0) begin
      $error("%0d cells never produced a result", expected_cells.size());
      errors++;
    end
    $display("Sent %0d cells, checked %0d results over %0d image geometries",
             cells_sent, results_checked, geometries);
    $display("Saw %0d image ends, %0d palette overflows, %0d input stall cycles",
             image_ends, overflows, in_stall_cycles);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tcpi_pkg.sv
rtl/tcpi_front.sv
rtl/tcpi_fifo.sv
rtl/tcpi_back.sv
rtl/text_cell_palette_indexer_top.sv
tb/sv/text_cell_palette_indexer_top_tb.sv
